// ===== rtl/csu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csu_pkg
// Shared types and constants for the cosine similarity unit.
// ----------------------------------------------------------------------------
package csu_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int SIM_W    = 16;
    localparam int Q_FRAC   = 14;
    localparam int QUO_W    = 2 * Q_FRAC + 1;
    localparam int ROOT_W   = Q_FRAC + 1;
    localparam int ROOT_IDX_W = 4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_NORM = 2'd1,
        ST_TOO_LONG  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_SQRT,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_a;
        logic signed [SAMPLE_W-1:0] sample_b;
        logic                       last;
    } t_in;

    typedef struct packed {
        logic signed [SIM_W-1:0] similarity;
        t_status                 status;
    } t_out;

endpackage

// ===== rtl/csu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csu_front
// Accepts sample pairs, forms products, accumulates the three running sums
// and hands a finished vector to the back end queue.
// ----------------------------------------------------------------------------
module csu_front import csu_pkg::*; #(
    parameter int MAX_LEN = 4096,
    parameter int SUM_W   = 2 * SAMPLE_W + $clog2(MAX_LEN + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_in                     i_data,
    output logic                    o_push,
    input  logic                    i_full,
    output logic signed [SUM_W-1:0] o_dot,
    output logic [SUM_W-1:0]        o_sa,
    output logic [SUM_W-1:0]        o_sb,
    output logic                    o_over
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [CNT_W-1:0]         r_cnt;
    logic                     r_pv;
    logic                     r_plast;
    logic                     r_pover;
    logic signed [PROD_W-1:0] r_pdot;
    logic [PROD_W-1:0]        r_paa;
    logic [PROD_W-1:0]        r_pbb;
    logic signed [SUM_W-1:0]  r_dot;
    logic [SUM_W-1:0]         r_sa;
    logic [SUM_W-1:0]         r_sb;

    logic                     sum_en;
    logic                     accept;
    logic                     advance;
    logic signed [PROD_W-1:0] prod_ab;
    logic signed [PROD_W-1:0] prod_aa;
    logic signed [PROD_W-1:0] prod_bb;
    logic signed [SUM_W-1:0]  n_dot;
    logic [SUM_W-1:0]         n_sa;
    logic [SUM_W-1:0]         n_sb;

    assign sum_en  = r_cnt < CNT_W'(MAX_LEN);
    assign advance = r_pv && (!r_plast || !i_full);
    assign o_ready = !(r_pv && r_plast && i_full);
    assign accept  = i_valid && o_ready;

    assign prod_ab = i_data.sample_a * i_data.sample_b;
    assign prod_aa = i_data.sample_a * i_data.sample_a;
    assign prod_bb = i_data.sample_b * i_data.sample_b;

    assign n_dot = r_dot + {{(SUM_W-PROD_W){r_pdot[PROD_W-1]}}, r_pdot};
    assign n_sa  = r_sa + {{(SUM_W-PROD_W){1'b0}}, r_paa};
    assign n_sb  = r_sb + {{(SUM_W-PROD_W){1'b0}}, r_pbb};

    assign o_push = advance && r_plast;
    assign o_dot  = n_dot;
    assign o_sa   = n_sa;
    assign o_sb   = n_sb;
    assign o_over = r_pover;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pv  <= 1'b0;
        end else begin
            if (accept) begin
                r_pv <= 1'b1;
                if (i_data.last) begin
                    r_cnt <= '0;
                end else if (sum_en) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end else if (advance) begin
                r_pv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_plast <= i_data.last;
            r_pover <= !sum_en;
            r_pdot  <= sum_en ? prod_ab : '0;
            r_paa   <= sum_en ? prod_aa : '0;
            r_pbb   <= sum_en ? prod_bb : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_sa  <= '0;
            r_sb  <= '0;
        end else if (advance) begin
            if (r_plast) begin
                r_dot <= '0;
                r_sa  <= '0;
                r_sb  <= '0;
            end else begin
                r_dot <= n_dot;
                r_sa  <= n_sa;
                r_sb  <= n_sb;
            end
        end
    end

endmodule

// ===== rtl/csu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csu_queue
// Two-entry register queue between the accumulator and the divider.
// ----------------------------------------------------------------------------
module csu_queue import csu_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_nempty,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full   = r_cnt == 2'd2;
    assign o_nempty = r_cnt != 2'd0;
    assign o_rdata  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ===== rtl/csu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csu_back
// Turns finished sums into the Q1.14 similarity: shift-add squaring of the
// dot product and product of the norms, restoring division, integer root.
// ----------------------------------------------------------------------------
module csu_back import csu_pkg::*; #(
    parameter int SUM_W = 45
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_job_valid,
    output logic                    o_pop,
    input  logic signed [SUM_W-1:0] i_dot,
    input  logic [SUM_W-1:0]        i_sa,
    input  logic [SUM_W-1:0]        i_sb,
    input  logic                    i_over,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_out                    o_data
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam int WIDE_W = 2 * SUM_W;

    t_back_state             r_state;
    t_back_state             n_state;
    logic [STEP_W-1:0]       r_step;
    logic [STEP_W-1:0]       n_step;
    logic                    r_neg;
    t_status                 r_status;
    logic [SUM_W-1:0]        r_ma;
    logic [SUM_W-1:0]        r_pb;
    logic [WIDE_W-1:0]       r_accm;
    logic [WIDE_W-1:0]       r_accp;
    logic [WIDE_W-1:0]       r_rem;
    logic [QUO_W-1:0]        r_quo;
    logic [ROOT_W-1:0]       r_root;
    logic                    r_out_valid;
    t_out                    r_out;

    logic                    out_load;
    logic                    zero_norm;
    logic [SUM_W-1:0]        dot_mag;
    logic [SUM_W:0]          sum_m;
    logic [SUM_W:0]          sum_p;
    logic [WIDE_W:0]         rem_sh;
    logic                    rem_ge;
    logic [WIDE_W:0]         rem_sub;
    logic [ROOT_W-1:0]       trial;
    logic [2*ROOT_W-1:0]     trial_sq;
    logic                    trial_ok;

    assign zero_norm = (i_sa == '0) || (i_sb == '0);
    assign dot_mag   = i_dot[SUM_W-1] ? SUM_W'(-i_dot) : SUM_W'(i_dot);

    assign sum_m = {1'b0, r_accm[WIDE_W-1:SUM_W]} + (r_accm[0] ? {1'b0, r_ma} : '0);
    assign sum_p = {1'b0, r_accp[WIDE_W-1:SUM_W]} + (r_accp[0] ? {1'b0, r_pb} : '0);

    assign rem_sh  = (r_step == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign rem_ge  = rem_sh >= {1'b0, r_accp};
    assign rem_sub = rem_sh - {1'b0, r_accp};

    assign trial    = r_root | (ROOT_W'(1) << r_step[ROOT_IDX_W-1:0]);
    assign trial_sq = trial * trial;
    assign trial_ok = trial_sq <= {{(2*ROOT_W-QUO_W){1'b0}}, r_quo};

    assign out_load = (r_state == BK_DONE) && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_pop   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_pop  = 1'b1;
                    n_step = '0;
                    if (i_over || zero_norm) begin
                        n_state = BK_DONE;
                    end else begin
                        n_state = BK_MUL;
                    end
                end
            end
            BK_MUL: begin
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = BK_DIV;
                    n_step  = '0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            BK_DIV: begin
                if (r_step == STEP_W'(QUO_W - 1)) begin
                    n_state = BK_SQRT;
                    n_step  = STEP_W'(ROOT_W - 1);
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            BK_SQRT: begin
                if (r_step == '0) begin
                    n_state = BK_DONE;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            BK_DONE: begin
                if (out_load) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                r_neg  <= i_dot[SUM_W-1];
                r_ma   <= dot_mag;
                r_pb   <= i_sb;
                r_accm <= {{SUM_W{1'b0}}, dot_mag};
                r_accp <= {{SUM_W{1'b0}}, i_sa};
                r_quo  <= '0;
                r_root <= '0;
                if (i_over) begin
                    r_status <= ST_TOO_LONG;
                end else if (zero_norm) begin
                    r_status <= ST_ZERO_NORM;
                end else begin
                    r_status <= ST_OK;
                end
            end
            BK_MUL: begin
                r_accm <= {sum_m, r_accm[SUM_W-1:1]};
                r_accp <= {sum_p, r_accp[SUM_W-1:1]};
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_rem <= {sum_m, r_accm[SUM_W-1:1]};
                end
            end
            BK_DIV: begin
                r_rem <= rem_ge ? rem_sub[WIDE_W-1:0] : rem_sh[WIDE_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], rem_ge};
            end
            BK_SQRT: begin
                if (trial_ok) begin
                    r_root <= trial;
                end
            end
            BK_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.status <= r_status;
            if (r_status != ST_OK) begin
                r_out.similarity <= '0;
            end else if (r_neg) begin
                r_out.similarity <= -SIM_W'(r_root);
            end else begin
                r_out.similarity <= SIM_W'(r_root);
            end
        end
    end

endmodule

// ===== rtl/cosine_similarity_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity_unit
// Streaming cosine similarity of two signed sample vectors in Q1.14.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready, i_data): one request per element pair,
// last set on the final pair; one request per cycle while o_ready is
// high, products registered on acceptance and then added to the sums.
// Output channel (o_valid/i_ready, o_data): one result per vector, with
// status ok, zero norm, or run longer than MAX_LEN (pairs past MAX_LEN are
// dropped from the sums).
// The back end works one vector at a time: it takes the sums, runs a
// shift-add multiply over SUM_W bits (SUM_W = 32 + clog2(MAX_LEN+1), 45 by
// default), a restoring division for a 29-bit quotient and an integer
// square root for a 15-bit root, then loads the result; error cases go
// from taking the sums straight to loading the result. A two-entry queue
// holds finished sums, so the front end only stalls when two vectors are
// waiting and a third ends. A stalled receiver holds the result register;
// the back end waits and the queue and front end fill behind it. Reset
// (synchronous, active low) clears the sums, count, queue and output.
// ----------------------------------------------------------------------------
module cosine_similarity_unit import csu_pkg::*; #(
    parameter int MAX_LEN = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int SUM_W = 2 * SAMPLE_W + $clog2(MAX_LEN + 1);
    localparam int JOB_W = 3 * SUM_W + 1;

    logic                    push;
    logic                    full;
    logic                    pop;
    logic                    job_valid;
    logic signed [SUM_W-1:0] f_dot;
    logic [SUM_W-1:0]        f_sa;
    logic [SUM_W-1:0]        f_sb;
    logic                    f_over;
    logic [JOB_W-1:0]        q_wdata;
    logic [JOB_W-1:0]        q_rdata;

    csu_front #(
        .MAX_LEN (MAX_LEN),
        .SUM_W   (SUM_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_push  (push),
        .i_full  (full),
        .o_dot   (f_dot),
        .o_sa    (f_sa),
        .o_sb    (f_sb),
        .o_over  (f_over)
    );

    assign q_wdata = {f_dot, f_sa, f_sb, f_over};

    csu_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (q_wdata),
        .o_full   (full),
        .i_pop    (pop),
        .o_nempty (job_valid),
        .o_rdata  (q_rdata)
    );

    csu_back #(
        .SUM_W (SUM_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_pop       (pop),
        .i_dot       (q_rdata[JOB_W-1 -: SUM_W]),
        .i_sa        (q_rdata[2*SUM_W -: SUM_W]),
        .i_sb        (q_rdata[SUM_W -: SUM_W]),
        .i_over      (q_rdata[0]),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// ===== verif/cosine_similarity_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity_unit_tb
// Self-checking testbench for the streaming cosine similarity unit.
// Drives element pairs as vectors of random length and content: extremes,
// zero norms, aligned and opposed vectors, a run one past MAX_LEN. A
// scoreboard keeps its own sums and predicts each Q1.14 result with an exact
// integer search; results are checked in order, field by field. Both sides
// idle in random bursts, the receiver holds off once long enough to fill
// the block, and the sender pauses once until all results have drained.
// ----------------------------------------------------------------------------
module cosine_similarity_unit_tb;
    import csu_pkg::*;

    localparam int MAX_LEN        = 4096;
    localparam int RANDOM_PAIRS   = 1200;
    localparam int CALM_PAIRS     = 300;
    localparam int HOLD_CYCLES    = 800;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum int {
        VEC_RANDOM,
        VEC_ALIGNED,
        VEC_OPPOSED,
        VEC_EXTREME,
        VEC_SMALL,
        VEC_ZERO_A,
        VEC_ZERO_B
    } t_vec_kind;

    class cosine_scoreboard;
        logic signed [43:0] dot_acc;
        logic [43:0]        sq_a_acc;
        logic [43:0]        sq_b_acc;
        logic [12:0]        pair_count;
        t_out               expected_sims[$];
        int                 errors;

        function new();
            clear_sums();
            errors = 0;
        endfunction

        function void clear_sums();
            dot_acc    = '0;
            sq_a_acc   = '0;
            sq_b_acc   = '0;
            pair_count = '0;
        endfunction

        function int pending();
            return expected_sims.size();
        endfunction

        // largest q in 0..16384 with q^2 * |a|^2 * |b|^2 <= dot^2 * 2^28
        function logic signed [15:0] cosine_q14();
            logic [127:0]       dot_mag;
            logic [127:0]       dot_scaled;
            logic [127:0]       norm_prod;
            logic [127:0]       trial;
            logic signed [15:0] sim;
            int                 lo;
            int                 hi;
            int                 mid;
            dot_mag    = 128'(dot_acc < 0 ? -dot_acc : dot_acc);
            dot_scaled = (dot_mag * dot_mag) << 28;
            norm_prod  = 128'(sq_a_acc) * 128'(sq_b_acc);
            lo = 0;
            hi = 16384;
            while (lo < hi) begin
                mid   = (lo + hi + 1) / 2;
                trial = 128'(mid * mid) * norm_prod;
                if (trial <= dot_scaled) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            sim = 16'(lo);
            if (dot_acc < 0) begin
                sim = -sim;
            end
            return sim;
        endfunction

        function void note_pair(t_in req);
            logic signed [31:0] prod_ab;
            logic signed [31:0] sq_a;
            logic signed [31:0] sq_b;
            t_out               exp_res;
            prod_ab = req.sample_a * req.sample_b;
            sq_a    = req.sample_a * req.sample_a;
            sq_b    = req.sample_b * req.sample_b;
            if (pair_count < MAX_LEN) begin
                dot_acc    = dot_acc + prod_ab;
                sq_a_acc   = sq_a_acc + 44'(sq_a);
                sq_b_acc   = sq_b_acc + 44'(sq_b);
                pair_count = pair_count + 1'b1;
            end else begin
                pair_count = 13'(MAX_LEN + 1);
            end
            if (!req.last) begin
                return;
            end
            exp_res.similarity = '0;
            if (pair_count > MAX_LEN) begin
                exp_res.status = ST_TOO_LONG;
            end else if (sq_a_acc == 0 || sq_b_acc == 0) begin
                exp_res.status = ST_ZERO_NORM;
            end else begin
                exp_res.status     = ST_OK;
                exp_res.similarity = cosine_q14();
            end
            expected_sims = {expected_sims, exp_res};
            clear_sums();
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_similarity(t_out res);
            t_out exp_res;
            if (expected_sims.size() == 0) begin
                report_mismatch($sformatf("unexpected result sim=%0d status=%0d",
                                          res.similarity, res.status));
                return;
            end
            exp_res = expected_sims.pop_front();
            if (res.similarity !== exp_res.similarity) begin
                report_mismatch($sformatf("similarity got %0d expected %0d",
                                          res.similarity, exp_res.similarity));
            end
            if (res.status !== exp_res.status) begin
                report_mismatch($sformatf("status got %0d expected %0d",
                                          res.status, exp_res.status));
            end
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data  = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    bit sender_gaps   = 1'b0;
    bit rx_stalls     = 1'b0;
    bit hold_req      = 1'b0;
    int pairs_offered = 0;

    cosine_scoreboard sb = new();

    cosine_similarity_unit #(
        .MAX_LEN (MAX_LEN)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_pair(i_data);
            end
            if (o_valid && i_ready) begin
                sb.check_similarity(o_data);
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_ready <= 1'b1;
            end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767) begin
            return 16'sd32767;
        end
        if (v < -32768) begin
            return -16'sd32768;
        end
        return 16'(v);
    endfunction

    function automatic logic signed [15:0] pick_extreme();
        unique case ($urandom_range(0, 4))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            default: return 16'sd1;
        endcase
    endfunction

    // entered and left just after a falling edge
    task automatic offer_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
        t_in req;
        req.sample_a = a;
        req.sample_b = b;
        req.last     = last;
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pairs_offered++;
        @(negedge i_clk);
    endtask

    task automatic send_vector(int len, t_vec_kind kind);
        logic signed [15:0] a;
        logic signed [15:0] b;
        int                 noise;
        for (int k = 0; k < len; k++) begin
            a     = 16'($urandom);
            b     = 16'($urandom);
            noise = int'($urandom_range(0, 64)) - 32;
            unique case (kind)
                VEC_ALIGNED: b = clamp16(int'(a) + noise);
                VEC_OPPOSED: b = clamp16(-int'(a) + noise);
                VEC_EXTREME: begin
                    a = pick_extreme();
                    b = pick_extreme();
                end
                VEC_SMALL: begin
                    a = 16'(int'($urandom_range(0, 8)) - 4);
                    b = 16'(int'($urandom_range(0, 8)) - 4);
                end
                VEC_ZERO_A: a = '0;
                VEC_ZERO_B: b = '0;
                default: ;
            endcase
            offer_pair(a, b, k == len - 1);
        end
    endtask

    task automatic send_random_vectors(int pair_budget);
        int        stop_at;
        int        pick;
        int        len;
        t_vec_kind kind;
        stop_at = pairs_offered + pair_budget;
        while (pairs_offered < stop_at) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                kind = VEC_ZERO_A;
            end else if (pick == 1) begin
                kind = VEC_ZERO_B;
            end else if (pick < 5) begin
                kind = VEC_EXTREME;
            end else if (pick < 8) begin
                kind = VEC_SMALL;
            end else if (pick < 12) begin
                kind = VEC_ALIGNED;
            end else if (pick < 15) begin
                kind = VEC_OPPOSED;
            end else begin
                kind = VEC_RANDOM;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
            send_vector(len, kind);
        end
    endtask

    task automatic wait_results_drained();
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        sender_gaps = 1'b1;
        rx_stalls   = 1'b1;

        // full-scale and unit single pairs, same and opposite sign
        offer_pair(16'sd32767, 16'sd32767, 1'b1);
        offer_pair(-16'sd32768, -16'sd32768, 1'b1);
        offer_pair(-16'sd32768, 16'sd32767, 1'b1);
        offer_pair(16'sd32767, -16'sd32768, 1'b1);
        offer_pair(-16'sd1, 16'sd1, 1'b1);
        // zero norms
        offer_pair(16'sd0, 16'sd7, 1'b1);
        offer_pair(-16'sd7, 16'sd0, 1'b1);
        offer_pair(16'sd0, 16'sd0, 1'b1);
        // orthogonal
        offer_pair(16'sd1, 16'sd0, 1'b0);
        offer_pair(16'sd0, -16'sd1, 1'b1);
        // partial cancel
        offer_pair(16'sd3, 16'sd4, 1'b0);
        offer_pair(16'sd4, -16'sd3, 1'b0);
        offer_pair(-16'sd32768, 16'sd12345, 1'b1);

        // one pair past MAX_LEN (too long wins over zero norm)
        send_vector(MAX_LEN + 1, VEC_ZERO_A);
        send_vector(2, VEC_EXTREME);

        // sender pauses until everything has drained
        i_valid <= 1'b0;
        wait_results_drained();
        @(negedge i_clk);

        // long receiver hold-off while requests keep coming
        hold_req = 1'b1;
        for (int v = 0; v < 30; v++) begin
            send_vector($urandom_range(1, 2), VEC_RANDOM);
        end

        send_random_vectors(RANDOM_PAIRS);

        sender_gaps = 1'b0;
        rx_stalls   = 1'b0;
        send_random_vectors(CALM_PAIRS);

        i_valid <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/csu_pkg.sv
rtl/csu_front.sv
rtl/csu_queue.sv
rtl/csu_back.sv
rtl/cosine_similarity_unit.sv
verif/cosine_similarity_unit_tb.sv
